FILE: sv/rtss_pkg.sv
// ----------------------------------------------------------------------------
// rtss_pkg
// shared types and codes of the sorted record table
// ----------------------------------------------------------------------------
package rtss_pkg;

   // operation kinds
   localparam logic [2:0] KIND_ADD     = 3'd0;
   localparam logic [2:0] KIND_LSEARCH = 3'd1;
   localparam logic [2:0] KIND_KSORT   = 3'd2;
   localparam logic [2:0] KIND_BSEARCH = 3'd3;
   localparam logic [2:0] KIND_SSORT   = 3'd4;
   localparam logic [2:0] KIND_DUMP    = 3'd5;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_DUP       = 3'd2;
   localparam logic [2:0] ST_BAD_KEY   = 3'd3;
   localparam logic [2:0] ST_BAD_SCORE = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;
   localparam logic [2:0] ST_NOT_SORT  = 3'd6;
   localparam logic [2:0] ST_EMPTY     = 3'd7;

   localparam logic [13:0] SCORE_MAX = 14'd10000;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] key;
      logic [13:0] score;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  position;
      logic [15:0] found_key;
      logic [13:0] found_score;
      logic [6:0]  fill;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] key;
      logic [13:0] score;
   } rec_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_ROTATE = 2'd1,
      OP_SORT   = 2'd2,
      OP_LOAD   = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        by_score;
   } cell_ctl_type;

   function automatic rsp_type mk_rsp(logic [2:0] status, logic [5:0] position,
                                      logic [15:0] key, logic [13:0] score,
                                      logic [6:0] fill, logic last);
      rsp_type r;
      r.status      = status;
      r.position    = position;
      r.found_key   = key;
      r.found_score = score;
      r.fill        = fill;
      r.last        = last;
      return r;
   endfunction

endpackage

FILE: sv/rtss_cell.sv
// ----------------------------------------------------------------------------
// rtss_cell
// one record slot: holds, rotates, loads or compare-exchanges with neighbors
// ----------------------------------------------------------------------------
module rtss_cell
   import rtss_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         pair_en,
   input  logic         load_en,
   input  logic         left_swap,
   input  rec_type      next_rec,
   input  rec_type      prev_rec,
   input  rec_type      load_rec,
   output rec_type      rec,
   output logic         swap_right
);

   rec_type rec_ff;
   rec_type rec_in;
   logic    out_of_order;

   assign rec = rec_ff;

   // descending by score, ascending by key; strict compare keeps equals in order
   assign out_of_order = ctl.by_score ? (rec_ff.score < next_rec.score)
                                      : (next_rec.key < rec_ff.key);
   assign swap_right   = (ctl.op == OP_SORT) && pair_en && out_of_order;

   always_comb begin
      rec_in = rec_ff;
      unique case (ctl.op)
         OP_ROTATE: rec_in = next_rec;
         OP_SORT: begin
            if (swap_right) rec_in = next_rec;
            else if (left_swap) rec_in = prev_rec;
         end
         OP_LOAD: if (load_en) rec_in = load_rec;
         default: rec_in = rec_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

FILE: sv/record_table_sort_search.sv
// ----------------------------------------------------------------------------
// record_table_sort_search
// record table of DEPTH keyed entries with sort, search and dump
// ----------------------------------------------------------------------------
// the table lives in a row of DEPTH cells, entry i in cell i. searches and
// adds rotate the whole row once past cell 0 so a single key comparator sees
// every entry; an add then writes its cell directly. sorts run DEPTH phases
// of odd-even compare-exchange between neighbor cells, one phase per cycle,
// which is a stable sort. binary search gives the same answer as a linear
// scan on a key-sorted table of unique keys, so it shares the scan. a dump
// can stall on rsp_ready for each entry; unused kinds get no response. a new
// item is taken only when the previous one is finished, but a result may
// still sit in the output register waiting for rsp_ready.
// ----------------------------------------------------------------------------
module record_table_sort_search
   import rtss_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_SCAN = 6'b000010,
      S_EVAL = 6'b000100,
      S_SORT = 6'b001000,
      S_DUMP = 6'b010000,
      S_RESP = 6'b100000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] step_ff, step_in;
   logic [CW-1:0] count_ff, count_in;
   logic          sorted_ff, sorted_in;
   req_type       req_ff, req_in;
   logic          hit_ff, hit_in;
   logic [CW-1:0] hit_pos_ff, hit_pos_in;
   logic [13:0]   hit_score_ff, hit_score_in;
   rsp_type       pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   cell_ctl_type  ctl;
   rec_type       load_rec;
   rec_type       rec [DEPTH];
   logic          swap [DEPTH];
   logic          last_step;
   logic          rsp_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign last_step = (step_ff == CW'(DEPTH - 1));
   assign load_rec  = '{key: req_ff.key, score: req_ff.score};

   // row of cells; the last cell wraps to cell 0 for rotation
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      rec_type prev_rec;
      logic    left_swap;
      logic    pair_en;
      if (i == 0) begin : g_head
         assign prev_rec  = rec[0];
         assign left_swap = 1'b0;
      end else begin : g_body
         assign prev_rec  = rec[i-1];
         assign left_swap = swap[i-1];
      end
      // even pairs on even phases, odd pairs on odd phases, only inside the fill
      assign pair_en = (step_ff[0] == 1'(i % 2)) && (CW'(i + 1) < count_ff);

      rtss_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .pair_en    (pair_en),
         .load_en    (count_ff == CW'(i)),
         .left_swap  (left_swap),
         .next_rec   (rec[(i + 1) % DEPTH]),
         .prev_rec   (prev_rec),
         .load_rec   (load_rec),
         .rec        (rec[i]),
         .swap_right (swap[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      sorted_in    = sorted_ff;
      req_in       = req_ff;
      hit_in       = hit_ff;
      hit_pos_in   = hit_pos_ff;
      hit_score_in = hit_score_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ctl.op       = OP_HOLD;
      ctl.by_score = (req_ff.kind == KIND_SSORT);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               step_in = '0;
               hit_in  = 1'b0;
               case (req_data.kind)
                  KIND_ADD: begin
                     if (count_ff == CW'(DEPTH)) begin
                        pend_in  = mk_rsp(ST_FULL, '0, '0, '0, 7'(count_ff), 1'b1);
                        state_in = S_RESP;
                     end else if (req_data.key == '0) begin
                        pend_in  = mk_rsp(ST_BAD_KEY, '0, '0, '0, 7'(count_ff), 1'b1);
                        state_in = S_RESP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  KIND_LSEARCH: state_in = S_SCAN;
                  KIND_BSEARCH: begin
                     if (sorted_ff) begin
                        state_in = S_SCAN;
                     end else begin
                        pend_in  = mk_rsp(ST_NOT_SORT, '0, '0, '0, 7'(count_ff), 1'b1);
                        state_in = S_RESP;
                     end
                  end
                  KIND_KSORT, KIND_SSORT: state_in = S_SORT;
                  KIND_DUMP: begin
                     if (count_ff == '0) begin
                        pend_in  = mk_rsp(ST_EMPTY, '0, '0, '0, 7'(count_ff), 1'b1);
                        state_in = S_RESP;
                     end else begin
                        state_in = S_DUMP;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         // cell 0 holds entry step during the rotation
         S_SCAN: begin
            ctl.op = OP_ROTATE;
            if ((step_ff < count_ff) && !hit_ff && (rec[0].key == req_ff.key)) begin
               hit_in       = 1'b1;
               hit_pos_in   = step_ff;
               hit_score_in = rec[0].score;
            end
            step_in = step_ff + 1'b1;
            if (last_step) state_in = S_EVAL;
         end

         // row is back in place
         S_EVAL: begin
            state_in = S_RESP;
            if (req_ff.kind == KIND_ADD) begin
               if (hit_ff) begin
                  pend_in = mk_rsp(ST_DUP, '0, '0, '0, 7'(count_ff), 1'b1);
               end else if (req_ff.score > SCORE_MAX) begin
                  pend_in = mk_rsp(ST_BAD_SCORE, '0, '0, '0, 7'(count_ff), 1'b1);
               end else begin
                  ctl.op    = OP_LOAD;
                  count_in  = count_ff + 1'b1;
                  sorted_in = 1'b0;
                  pend_in   = mk_rsp(ST_OK, 6'(count_ff), req_ff.key, req_ff.score,
                                     7'(count_ff + 1'b1), 1'b1);
               end
            end else if (hit_ff) begin
               pend_in = mk_rsp(ST_OK, 6'(hit_pos_ff), req_ff.key, hit_score_ff,
                                7'(count_ff), 1'b1);
            end else begin
               pend_in = mk_rsp(ST_NOT_FOUND, '0, '0, '0, 7'(count_ff), 1'b1);
            end
         end

         S_SORT: begin
            ctl.op  = OP_SORT;
            step_in = step_ff + 1'b1;
            if (last_step) begin
               sorted_in = (req_ff.kind == KIND_KSORT);
               pend_in   = mk_rsp(ST_OK, '0, '0, '0, 7'(count_ff), 1'b1);
               state_in  = S_RESP;
            end
         end

         // emit live entries as they pass cell 0, then finish the rotation
         S_DUMP: begin
            if ((step_ff >= count_ff) || rsp_free) begin
               ctl.op  = OP_ROTATE;
               step_in = step_ff + 1'b1;
               if (step_ff < count_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = mk_rsp(ST_OK, 6'(step_ff), rec[0].key, rec[0].score,
                                  7'(count_ff), (step_ff + 1'b1) == count_ff);
               end
               if (last_step) state_in = S_IDLE;
            end
         end

         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sorted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sorted_ff    <= sorted_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      hit_pos_ff   <= hit_pos_in;
      hit_score_ff <= hit_score_in;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
   end

endmodule
